>>> rtl/core/midi_csw_pkg.sv
package midi_csw_pkg;

    // Verdict codes carried on the status field
    typedef enum logic [2:0] {
        ST_VALID      = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_TRACK  = 3'd2,
        ST_TRUNCATED  = 3'd3,
        ST_TOO_LARGE  = 3'd4
    } status_t;

    // Walk phases, one-hot
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_CHDR   = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_TAIL   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    localparam logic [31:0] MAX_SIZE_RESET = 32'd52428800;  // 50 MiB
    localparam logic [31:0] HEADER_LEN     = 32'd14;        // magic + length + 6
    localparam logic [33:0] CHUNK_HDR_LEN  = 34'd8;
    localparam logic [7:0]  FORMAT_MAX     = 8'd2;

    localparam logic [3:0]  POS_FORMAT_HI  = 4'd8;
    localparam logic [3:0]  POS_FORMAT_LO  = 4'd9;
    localparam logic [3:0]  POS_TRACKS_HI  = 4'd10;
    localparam logic [3:0]  POS_TRACKS_LO  = 4'd11;
    localparam logic [3:0]  POS_DIVISION   = 4'd12;
    localparam logic [3:0]  POS_HDR_END    = 4'd13;

    // "MThd" followed by the big-endian header length of 6
    function automatic logic [7:0] hdr_magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h4D;
            3'd1:    val = 8'h54;
            3'd2:    val = 8'h68;
            3'd3:    val = 8'h64;
            3'd7:    val = 8'h06;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // "MTrk"
    function automatic logic [7:0] trk_magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = 8'h4D;
            2'd1:    val = 8'h54;
            2'd2:    val = 8'h72;
            default: val = 8'h6B;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/core/midi_chunk_size_walker_unit.sv
// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  --------------------------------
// in        sink       in_valid/in_stall   data_byte[7:0], last
// out       source     out_valid/out_stall status[2:0], walk_size[31:0],
//                                          track_count[15:0]
// cfg       sink       cfg_wr_en           cfg_wr_data[31:0] (max file size)
//
// One byte item per cycle while out is not stalled; a verdict reaches out after
// its byte is accepted, by way of the input register, then the result register.
// The walk state advances in one pass of compare, shift and a 34-bit add and
// compare against the size limit, between the input and result registers.
// Reset (rst_n low, async) returns to the header phase with the size limit
// at 50 MiB. A stall on out holds the result register and, once the input
// register is full, raises in_stall in the same cycle.
module midi_chunk_size_walker_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] walk_size,
    output logic [15:0] track_count,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import midi_csw_pkg::*;

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_fire;

    // Walk state
    phase_t      phase_reg,       phase_next;
    logic [3:0]  cnt_reg,         cnt_next;        // header position / chunk header offset
    logic [23:0] field_reg,       field_next;      // collects header fields and lengths
    logic [15:0] tracks_left_reg, tracks_left_next;
    logic [15:0] hdr_tracks_reg,  hdr_tracks_next;
    logic [31:0] chunk_end_reg,   chunk_end_next;  // next chunk start, then walked size
    logic [31:0] remain_reg,      remain_next;     // body bytes still to come
    logic [31:0] max_size_reg;

    // Result register
    logic        out_valid_reg,   out_valid_next;
    status_t     status_reg;
    logic [31:0] walk_size_reg;
    logic [15:0] track_count_reg;

    // Step results
    logic        emit;
    status_t     emit_st;
    logic [31:0] emit_size;
    logic [15:0] emit_trk;
    phase_t      walk_phase;
    logic [31:0] chunk_len;
    logic [33:0] chunk_sum;
    logic [15:0] tracks_dec;

    // Advance the input register whenever the result slot is free
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign walk_size   = walk_size_reg;
    assign track_count = track_count_reg;

    assign chunk_len  = {field_reg, s1_byte_reg};
    assign chunk_sum  = {2'b00, chunk_end_reg} + CHUNK_HDR_LEN + {2'b00, chunk_len};
    assign tracks_dec = tracks_left_reg - 16'd1;

    always_comb
    begin
        walk_phase       = phase_reg;
        cnt_next         = cnt_reg;
        field_next       = field_reg;
        tracks_left_next = tracks_left_reg;
        hdr_tracks_next  = hdr_tracks_reg;
        chunk_end_next   = chunk_end_reg;
        remain_next      = remain_reg;
        emit             = 1'b0;
        emit_st          = ST_VALID;

        unique case (phase_reg)
            PH_HEADER:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg < POS_FORMAT_HI)
                begin
                    if (s1_byte_reg != hdr_magic_byte(cnt_reg[2:0]))
                    begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_HEADER;
                    end
                end
                else if (cnt_reg == POS_FORMAT_HI || cnt_reg == POS_TRACKS_HI)
                begin
                    field_next = {16'd0, s1_byte_reg};
                end
                else if (cnt_reg == POS_FORMAT_LO)
                begin
                    if (field_reg[7:0] != 8'd0 || s1_byte_reg > FORMAT_MAX)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_HEADER;
                    end
                end
                else if (cnt_reg == POS_TRACKS_LO)
                begin
                    hdr_tracks_next = {field_reg[7:0], s1_byte_reg};
                    if ({field_reg[7:0], s1_byte_reg} == 16'd0)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_HEADER;
                    end
                end
                else if (cnt_reg == POS_HDR_END)
                begin
                    // Header done: start the first chunk header
                    walk_phase       = PH_CHDR;
                    tracks_left_next = hdr_tracks_reg;
                    chunk_end_next   = HEADER_LEN;
                    field_next       = 24'd0;
                    cnt_next         = 4'd0;
                    if (HEADER_LEN > max_size_reg)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_TOO_LARGE;
                    end
                end
                else
                begin
                    // time division byte: not checked
                    cnt_next = (cnt_reg == POS_DIVISION) ? POS_HDR_END : cnt_reg;
                end
            end
            PH_CHDR:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (!cnt_reg[2])
                begin
                    if (s1_byte_reg != trk_magic_byte(cnt_reg[1:0]))
                    begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_TRACK;
                    end
                end
                else if (cnt_reg[1:0] != 2'd3)
                begin
                    field_next = {field_reg[15:0], s1_byte_reg};
                end
                else
                begin
                    // Last length byte: close the chunk
                    field_next       = 24'd0;
                    cnt_next         = 4'd0;
                    tracks_left_next = tracks_dec;
                    remain_next      = chunk_len;
                    chunk_end_next   = chunk_sum[31:0];
                    if (chunk_sum > {2'b00, max_size_reg})
                    begin
                        emit    = 1'b1;
                        emit_st = ST_TOO_LARGE;
                    end
                    else if (tracks_dec == 16'd0)
                    begin
                        walk_phase = PH_TAIL;
                        if (chunk_len == 32'd0)
                        begin
                            emit    = 1'b1;
                            emit_st = ST_VALID;
                        end
                    end
                    else
                    begin
                        walk_phase = (chunk_len == 32'd0) ? PH_CHDR : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    walk_phase = PH_CHDR;
                    cnt_next   = 4'd0;
                end
            end
            PH_TAIL:
            begin
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    emit    = 1'b1;
                    emit_st = ST_VALID;
                end
            end
            PH_DONE:
            begin
                // drop bytes until the last one
            end
            default:
            begin
                walk_phase = PH_DONE;
            end
        endcase

        emit_trk = (walk_phase != PH_HEADER) ? hdr_tracks_next : 16'd0;

        if (s1_last_reg && !emit && walk_phase != PH_DONE)
        begin
            emit    = 1'b1;
            emit_st = ST_TRUNCATED;
        end

        emit_size  = (emit_st == ST_VALID) ? chunk_end_next : 32'd0;
        phase_next = emit ? PH_DONE : walk_phase;

        // Restart on a new file after the last byte
        if (s1_last_reg)
        begin
            phase_next       = PH_HEADER;
            cnt_next         = 4'd0;
            field_next       = 24'd0;
            tracks_left_next = 16'd0;
            hdr_tracks_next  = 16'd0;
            chunk_end_next   = HEADER_LEN;
            remain_next      = 32'd0;
        end
    end

    always_comb
    begin
        if (s1_fire)
            out_valid_next = emit;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_HEADER;
            cnt_reg         <= 4'd0;
            field_reg       <= 24'd0;
            tracks_left_reg <= 16'd0;
            hdr_tracks_reg  <= 16'd0;
            chunk_end_reg   <= HEADER_LEN;
            remain_reg      <= 32'd0;
            max_size_reg    <= MAX_SIZE_RESET;
        end
        else
        begin
            // Hold the input register until its byte is walked
            if (!s1_valid_reg || s1_fire)
                s1_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                max_size_reg <= cfg_wr_data;
            if (s1_fire)
            begin
                phase_reg       <= phase_next;
                cnt_reg         <= cnt_next;
                field_reg       <= field_next;
                tracks_left_reg <= tracks_left_next;
                hdr_tracks_reg  <= hdr_tracks_next;
                chunk_end_reg   <= chunk_end_next;
                remain_reg      <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || s1_fire)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
        end
        if (s1_fire && emit)
        begin
            status_reg      <= emit_st;
            walk_size_reg   <= emit_size;
            track_count_reg <= emit_trk;
        end
    end

    // A walk that passes always covers the header and at least one chunk header
    a_valid_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_VALID |-> walk_size_reg >= 32'd22)
        else $error("valid verdict with a size below header plus one chunk");

    a_fail_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_VALID |-> walk_size_reg == 32'd0)
        else $error("failing verdict carries a nonzero size");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> cnt_reg <= POS_HDR_END)
        else $error("header position past the header");

    a_body_remain: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY || phase_reg == PH_TAIL |-> remain_reg != 32'd0)
        else $error("body phase with no bytes left");

    a_walk_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHDR || phase_reg == PH_BODY
        |-> tracks_left_reg != 16'd0 && tracks_left_reg <= hdr_tracks_reg)
        else $error("track countdown out of range");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && emit |=> out_valid_reg)
        else $error("verdict lost on the way to the result register");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import midi_csw_pkg::*;

    // "MThd" followed by the big-endian header length of 6, and "MTrk"
    localparam logic [63:0] SMF_HDR_SIG = 64'h4D546864_00000006;
    localparam logic [31:0] SMF_TRK_SIG = 32'h4D54726B;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          ITEMS_PER_PHASE = 175;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LONG_HOLD = 400;

    typedef struct {
        status_t     code;
        logic [31:0] size;
        logic [15:0] tracks;
    } verdict_t;

    // Scoreboard: walks every accepted byte the way the block should, queues the
    // verdict each file earns, and compares every result against the oldest one.
    class verdict_scoreboard;
        logic [31:0] size_limit;
        phase_t      walk_phase;
        logic [47:0] pos;
        logic [31:0] field_acc;
        logic [15:0] tracks_left;
        logic [15:0] hdr_tracks;
        logic [47:0] chunk_end;
        verdict_t    due[$];
        int          mismatches;

        function new();
            size_limit = MAX_SIZE_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            walk_phase  = PH_HEADER;
            pos         = '0;
            field_acc   = '0;
            tracks_left = '0;
            hdr_tracks  = '0;
            chunk_end   = 48'd14;
        endfunction

        function void give(status_t code);
            verdict_t v;
            v.code   = code;
            v.size   = (code == ST_VALID) ? chunk_end[31:0] : 32'd0;
            v.tracks = (walk_phase != PH_HEADER) ? hdr_tracks : 16'd0;
            due.push_back(v);
            walk_phase = PH_DONE;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            logic [47:0] nxt;
            logic [2:0]  off;
            int          due_start;
            due_start = due.size();
            nxt = pos + 48'd1;
            case (walk_phase)
                PH_HEADER: begin
                    if (pos < 48'd8) begin
                        if (b != 8'(SMF_HDR_SIG >> (56 - 8 * int'(pos[2:0]))))
                            give(ST_BAD_HEADER);
                    end else if (pos == 48'd8 || pos == 48'd10) begin
                        field_acc = 32'(b);
                    end else if (pos == 48'd9) begin
                        if ({field_acc[23:0], b} > 32'd2)
                            give(ST_BAD_HEADER);
                    end else if (pos == 48'd11) begin
                        hdr_tracks = {field_acc[7:0], b};
                        if (hdr_tracks == 16'd0)
                            give(ST_BAD_HEADER);
                    end else if (pos == 48'd13) begin
                        walk_phase  = PH_CHDR;
                        tracks_left = hdr_tracks;
                        chunk_end   = 48'd14;
                        field_acc   = '0;
                        if (chunk_end > 48'(size_limit))
                            give(ST_TOO_LARGE);
                    end
                end
                PH_CHDR: begin
                    off = 3'(pos - chunk_end);
                    if (off < 3'd4) begin
                        if (b != 8'(SMF_TRK_SIG >> (24 - 8 * int'(off))))
                            give(ST_BAD_TRACK);
                    end else begin
                        field_acc = {field_acc[23:0], b};
                        if (off == 3'd7) begin
                            chunk_end   = chunk_end + 48'd8 + 48'(field_acc);
                            field_acc   = '0;
                            tracks_left = tracks_left - 16'd1;
                            if (chunk_end > 48'(size_limit))
                                give(ST_TOO_LARGE);
                            else if (tracks_left == 16'd0)
                                walk_phase = PH_TAIL;
                            else
                                walk_phase = (nxt == chunk_end) ? PH_CHDR : PH_BODY;
                            if (due.size() == due_start && tracks_left == 16'd0 &&
                                nxt == chunk_end)
                                give(ST_VALID);
                        end
                    end
                end
                PH_BODY: begin
                    if (nxt == chunk_end)
                        walk_phase = PH_CHDR;
                end
                PH_TAIL: begin
                    if (nxt == chunk_end)
                        give(ST_VALID);
                end
                default: ;
            endcase
            if (walk_phase != PH_DONE)
                pos = nxt;
            if (fin) begin
                if (due.size() == due_start && walk_phase != PH_DONE)
                    give(ST_TRUNCATED);
                restart();
            end
        endfunction

        function void check_verdict(logic [2:0] st, logic [31:0] fs, logic [15:0] tc);
            verdict_t exp;
            if (due.size() == 0) begin
                $error("verdict with none due: status %0d size %0d tracks %0d",
                       st, fs, tc);
                mismatches++;
                return;
            end
            exp = due.pop_front();
            if (st !== exp.code) begin
                $error("status: expected %0d, got %0d", exp.code, st);
                mismatches++;
            end
            if (fs !== exp.size) begin
                $error("walk_size: expected %0d, got %0d", exp.size, fs);
                mismatches++;
            end
            if (tc !== exp.tracks) begin
                $error("track_count: expected %0d, got %0d", exp.tracks, tc);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] walk_size;
    logic [15:0] track_count;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;

    verdict_scoreboard verdicts;
    logic [7:0]  file_bytes[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          phase_items = 0;
    int          cycle_count = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    midi_chunk_size_walker_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .walk_size   (walk_size),
        .track_count (track_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side: check what the block hands over at this edge, then pick the
    // stall for the next cycle. A pending long hold overrides the random stall
    // and is counted down here, so the sender keeps pushing while it runs.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            verdicts.check_verdict(status, walk_size, track_count);
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one byte, after a random idle gap, and hold it until accepted.
    // Valid is only touched once per edge: dropped for a gap, or kept high.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= fin;
        do
            @(posedge clk);
        while (in_stall);
        verdicts.note_byte(b, fin);
        phase_items++;
    endtask

    // Push the staged file out byte by byte, marking the final one
    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    function automatic void put_header(logic [15:0] fmt, logic [15:0] ntrk,
                                       logic [15:0] division);
        int i;
        for (i = 0; i < 8; i++)
            file_bytes.push_back(8'(SMF_HDR_SIG >> (56 - 8 * i)));
        file_bytes.push_back(fmt[15:8]);
        file_bytes.push_back(fmt[7:0]);
        file_bytes.push_back(ntrk[15:8]);
        file_bytes.push_back(ntrk[7:0]);
        file_bytes.push_back(division[15:8]);
        file_bytes.push_back(division[7:0]);
    endfunction

    // Chunk header with the given length, then body_n random body bytes
    function automatic void put_track(logic [31:0] len, int body_n);
        int i;
        for (i = 0; i < 4; i++)
            file_bytes.push_back(8'(SMF_TRK_SIG >> (24 - 8 * i)));
        for (i = 0; i < 4; i++)
            file_bytes.push_back(8'(len >> (24 - 8 * i)));
        for (i = 0; i < body_n; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    // Build one candidate file: mostly well-formed walks with random content,
    // then broken headers, oversized chunks and plain noise.
    task automatic random_file();
        int          kind, ntrk, len, i, keep, idx;
        logic [15:0] fmt;
        logic [31:0] big;
        kind = $urandom_range(99);
        if (kind < 60) begin
            ntrk = ($urandom_range(9) == 0) ? $urandom_range(7, 1) : $urandom_range(3, 1);
            put_header(16'($urandom_range(2)), 16'(ntrk), 16'($urandom));
            for (i = 0; i < ntrk; i++) begin
                len = $urandom_range(24);
                put_track(32'(len), len);
            end
            repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
            // Cut it short or flip one bit now and then
            if ($urandom_range(99) < 12) begin
                keep = $urandom_range(file_bytes.size(), 1);
                while (file_bytes.size() > keep)
                    void'(file_bytes.pop_back());
            end
            if ($urandom_range(99) < 10) begin
                idx = $urandom_range(file_bytes.size() - 1);
                file_bytes[idx] = file_bytes[idx] ^ 8'(1 << $urandom_range(7));
            end
        end else if (kind < 75) begin
            case ($urandom_range(2))
                0:       fmt = 16'($urandom);
                1:       fmt = 16'd3;
                default: fmt = 16'($urandom_range(2));
            endcase
            case ($urandom_range(2))
                0:       ntrk = 0;
                1:       ntrk = 16'hFFFF;
                default: ntrk = $urandom_range(65535);
            endcase
            put_header(fmt, 16'(ntrk), 16'($urandom));
            if ($urandom_range(1) == 1)
                put_track(32'($urandom_range(6)), $urandom_range(6));
            if ($urandom_range(1) == 1) begin
                idx = $urandom_range(13);
                file_bytes[idx] = 8'($urandom);
            end
        end else if (kind < 88) begin
            // Oversized chunk: too large against the limit, or truncated
            big = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
            if ($urandom_range(1) == 1)
                big = 32'($urandom_range(400));
            put_header(16'($urandom_range(2)), 16'($urandom_range(2, 1)), 16'($urandom));
            put_track(big, $urandom_range(5));
        end else begin
            if ($urandom_range(1) == 1) begin
                file_bytes.push_back(8'h4D);
                file_bytes.push_back(8'h54);
            end
            repeat ($urandom_range(20, 1)) file_bytes.push_back(8'($urandom));
        end
        send_file();
    endtask

    // Register writes only with the block drained: no result due and a few
    // quiet cycles so that bytes that earn no verdict have passed through.
    task automatic write_limit(input logic [31:0] v);
        in_valid <= 1'b0;
        while (verdicts.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        verdicts.size_limit = v;
    endtask

    initial
    begin
        int ph;
        logic [31:0] limit;
        verdicts = new;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset limit, a wrong first byte and a lone magic byte, each
        // as the final byte, then the smallest complete file (format 2, one
        // empty track, division all ones) whose verdict lands on the final byte.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b1);
        put_header(16'd2, 16'd1, 16'hFFFF);
        put_track(32'd0, 0);
        send_file();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       limit = 32'hFFFF_FFFF;
                1:       limit = 32'd14;
                2:       limit = 32'($urandom_range(400, 30));
                3:       limit = $urandom_range(32'hFFFF_FFFF, 32'd14);
                4:       limit = 32'($urandom_range(400, 30));
                5:       limit = MAX_SIZE_RESET;
                6:       limit = 32'($urandom_range(60, 14));
                default: limit = 32'hFFFF_FFFF;
            endcase
            write_limit(limit);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 59; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 8;  stall_pct = 8;  end
            endcase
            // Back-pressure long enough to fill the block and stall its input
            if (ph == 4)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                random_file();
        end

        in_valid <= 1'b0;
        while (verdicts.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (verdicts.mismatches == 0 && verdicts.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/midi_csw_pkg.sv
rtl/core/midi_chunk_size_walker_unit.sv
tb/sv/tb.sv
